### design/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg: shared types and constants of the stack machine executor
// Opcodes, operand kinds, status codes, state encoding, Q32.32 helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

	localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam int unsigned MUL_LAST  = 4;
	localparam int unsigned DIV_LAST  = 95;
	localparam int unsigned SQRT_LAST = 47;

	typedef enum logic [4:0] {
		OP_PUSH = 5'd0,
		OP_POP  = 5'd1,
		OP_ADD  = 5'd2,
		OP_SUB  = 5'd3,
		OP_MUL  = 5'd4,
		OP_DIV  = 5'd5,
		OP_SQRT = 5'd6,
		OP_OUT  = 5'd7,
		OP_IN   = 5'd8,
		OP_JMP  = 5'd9,
		OP_JE   = 5'd10,
		OP_JA   = 5'd11,
		OP_JB   = 5'd12,
		OP_JAE  = 5'd13,
		OP_JBE  = 5'd14,
		OP_JNE  = 5'd15,
		OP_CALL = 5'd16,
		OP_RET  = 5'd17,
		OP_HLT  = 5'd18
	} op_t;

	localparam logic [1:0] KIND_IMM     = 2'd0;
	localparam logic [1:0] KIND_REG     = 2'd1;
	localparam logic [1:0] KIND_RAM_IMM = 2'd2;
	localparam logic [1:0] KIND_RAM_REG = 2'd3;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_HALT   = 3'd1,
		ST_BADOP  = 3'd2,
		ST_BADARG = 3'd3,
		ST_STACK  = 3'd4,
		ST_RAM    = 3'd5,
		ST_ARITH  = 3'd6
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_EXEC  = 5'b00100,
		S_ALU   = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		ALU_MUL  = 2'd0,
		ALU_DIV  = 2'd1,
		ALU_SQRT = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic        start;
		alu_op_t     op;
		logic [63:0] top;
		logic [63:0] sec;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} alu_rsp_t;

	function automatic logic [63:0] q_mag(input logic [63:0] v);
		q_mag = v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] q_sat(input logic neg, input logic [63:0] m,
			input logic ovf);
		if (neg) begin
			q_sat = (ovf || (m > Q_MIN)) ? Q_MIN : (64'd0 - m);
		end else begin
			q_sat = (ovf || (m > Q_MAX)) ? Q_MAX : m;
		end
	endfunction

	function automatic logic [63:0] q_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if ((a[63] == b[63]) && (s[63] != a[63])) begin
			q_add = a[63] ? Q_MIN : Q_MAX;
		end else begin
			q_add = s;
		end
	endfunction

	function automatic logic [63:0] q_sub(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] d;
		d = a - b;
		if ((a[63] != b[63]) && (d[63] != a[63])) begin
			q_sub = a[63] ? Q_MIN : Q_MAX;
		end else begin
			q_sub = d;
		end
	endfunction

endpackage

`default_nettype wire

### design/sme_if.sv
// ----------------------------------------------------------------------------
// sme_if: item channels of the stack machine executor
// Instruction channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sme_cmd_if;
	logic               valid;
	logic               ready;
	logic        [4:0]  mode;
	logic        [1:0]  arg_kind;
	logic        [1:0]  reg_index;
	logic signed [63:0] immediate;
	logic        [15:0] pc;
	logic signed [63:0] in_value;

	modport source (output valid, mode, arg_kind, reg_index, immediate, pc, in_value,
		input ready);
	modport sink (input valid, mode, arg_kind, reg_index, immediate, pc, in_value,
		output ready);
endinterface

interface sme_rsp_if;
	logic               valid;
	logic               ready;
	logic        [15:0] next_pc;
	logic signed [63:0] out_value;
	logic               out_valid;
	logic        [2:0]  status;

	modport source (output valid, next_pc, out_value, out_valid, status, input ready);
	modport sink (input valid, next_pc, out_value, out_valid, status, output ready);
endinterface

`default_nettype wire

### design/sme_alu.sv
// ----------------------------------------------------------------------------
// sme_alu: multi-cycle Q32.32 arithmetic unit
// Multiply by 32x32 partial products, restoring divide and square root
// one bit per cycle, with saturation of the multiply and divide results.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sme_pkg::alu_req_t req,
	output sme_pkg::alu_rsp_t      rsp
);

	logic              busy_q;
	logic              done_q;
	sme_pkg::alu_op_t  op_q;
	logic [6:0]        cnt_q;
	logic              neg_q;
	logic [63:0]       ma_q;
	logic [63:0]       mb_q;
	logic [127:0]      acc_q;
	logic [63:0]       pp_q;
	logic [1:0]        psh_q;
	logic [63:0]       r_q;
	logic [63:0]       quo_q;
	logic              ovf_q;
	logic [95:0]       rad_q;
	logic [47:0]       root_q;
	logic [51:0]       rem_q;

	logic [6:0]   last;
	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [127:0] pp_shift;
	logic [64:0]  rn;
	logic [51:0]  rem_n;
	logic [51:0]  trial;

	always_comb begin
		case (op_q)
			sme_pkg::ALU_MUL:  last = 7'(sme_pkg::MUL_LAST);
			sme_pkg::ALU_DIV:  last = 7'(sme_pkg::DIV_LAST);
			default:           last = 7'(sme_pkg::SQRT_LAST);
		endcase
		a_half = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		b_half = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
		case (psh_q)
			2'd0:    pp_shift = {64'd0, pp_q};
			2'd1:    pp_shift = {32'd0, pp_q, 32'd0};
			default: pp_shift = {pp_q, 64'd0};
		endcase
		rn    = {r_q, ma_q[63]};
		rem_n = {rem_q[49:0], rad_q[95:94]};
		trial = {2'b00, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q   <= req.op;
			neg_q  <= req.top[63] ^ req.sec[63];
			acc_q  <= '0;
			r_q    <= '0;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
			rad_q  <= {req.top, 32'd0};
			root_q <= '0;
			rem_q  <= '0;
			if (req.op == sme_pkg::ALU_MUL) begin
				ma_q <= sme_pkg::q_mag(req.top);
				mb_q <= sme_pkg::q_mag(req.sec);
			end else begin
				ma_q <= sme_pkg::q_mag(req.sec);
				mb_q <= sme_pkg::q_mag(req.top);
			end
		end else if (busy_q) begin
			case (op_q)
				sme_pkg::ALU_MUL: begin
					pp_q  <= a_half * b_half;
					psh_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
					if (cnt_q != 7'd0) begin
						acc_q <= acc_q + pp_shift;
					end
				end
				sme_pkg::ALU_DIV: begin
					ma_q  <= {ma_q[62:0], 1'b0};
					ovf_q <= ovf_q | quo_q[63];
					if (rn >= {1'b0, mb_q}) begin
						r_q   <= 64'(rn - {1'b0, mb_q});
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						r_q   <= rn[63:0];
						quo_q <= {quo_q[62:0], 1'b0};
					end
				end
				default: begin
					rad_q <= {rad_q[93:0], 2'b00};
					if (rem_n >= trial) begin
						rem_q  <= rem_n - trial;
						root_q <= {root_q[46:0], 1'b1};
					end else begin
						rem_q  <= rem_n;
						root_q <= {root_q[46:0], 1'b0};
					end
				end
			endcase
		end
	end

	always_comb begin
		rsp.done = done_q;
		case (op_q)
			sme_pkg::ALU_MUL:
				rsp.result = sme_pkg::q_sat(neg_q, acc_q[95:32], |acc_q[127:96]);
			sme_pkg::ALU_DIV:
				rsp.result = sme_pkg::q_sat(neg_q, quo_q, ovf_q);
			default:
				rsp.result = {16'd0, root_q};
		endcase
	end

endmodule

`default_nettype wire

### design/stack_machine_executor.sv
// ----------------------------------------------------------------------------
// stack_machine_executor: executes one decoded stack machine instruction
// Operand stack and data RAM in synchronous memories, registers in flops.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one decoded instruction per item (opcode, operand kind,
//   register number, immediate, pc and the IN value). rsp returns one item
//   per instruction: next pc, OUT value with its flag, and a status code.
//   One instruction is in flight at a time; cmd.ready is high only while
//   the executor is idle.
//   Mul, div and sqrt run in the shared arithmetic unit (two multiply stages
//   over four partial products, one quotient or root bit per cycle); all
//   other instructions finish without it. A new item is taken only after
//   the previous one has moved to the output register.
//   Stack and RAM reads go out in the accept cycle; writes land in the
//   execute or arithmetic-done cycle.
//   After reset the data RAM is swept to zero, one word per cycle, over all
//   RAM_WORDS words; cmd.ready stays low meanwhile. Stack count and the
//   register file clear at once.
//   When rsp is stalled the finished item holds in the output register and
//   the next item waits until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_executor #(
	parameter int STACK_DEPTH = 64,
	parameter int NUM_REGS    = 4,
	parameter int RAM_WORDS   = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	sme_cmd_if.sink  cmd,
	sme_rsp_if.source rsp
);

	localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam int RIW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int RAW = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;

	logic [63:0] stk_mem [STACK_DEPTH];
	logic [63:0] ram_mem [RAM_WORDS];
	logic [63:0] regs_q  [NUM_REGS];

	sme_pkg::state_t state_q;
	logic [SCW-1:0]  sc_q;
	logic [RAW-1:0]  clr_q;

	logic [4:0]      mode_q;
	logic [1:0]      kind_q;
	logic [RIW-1:0]  ridx_q;
	logic [63:0]     imm_q;
	logic [15:0]     pc_q;
	logic [63:0]     inv_q;
	logic [63:0]     rval_q;
	logic [2:0]      opst_q;
	logic [RAW-1:0]  raddr_q;
	logic [63:0]     top_q;
	logic [63:0]     sec_q;
	logic [63:0]     ramrd_q;
	logic [SAW-1:0]  wb_addr_q;
	logic [SCW-1:0]  wb_sc_q;

	logic [15:0]     res_next_q;
	logic [63:0]     res_ov_q;
	logic            res_ovld_q;
	logic [2:0]      res_st_q;

	logic            ovalid_q;
	logic [15:0]     onext_q;
	logic [63:0]     oval_q;
	logic            oflag_q;
	logic [2:0]      ost_q;

	logic            accept;
	logic            slot_free;
	logic [RIW-1:0]  ridx;
	logic            reg_ok;
	logic [63:0]     rval;
	logic [63:0]     addr_src;
	logic            ram_ok;
	logic [2:0]      opst;
	logic [SCW-1:0]  sc_m1;
	logic [SCW-1:0]  sc_m2;

	logic [63:0]     v_opnd;
	logic [15:0]     next_len;
	logic [15:0]     target;
	logic            take;
	logic [2:0]      ex_st;
	logic [15:0]     ex_next;
	logic [63:0]     ex_ov;
	logic            ex_ovld;
	logic            stk_wr;
	logic [SAW-1:0]  stk_wa;
	logic [63:0]     stk_wd;
	logic [SCW-1:0]  sc_nxt;
	logic            reg_wr;
	logic            ram_wr;
	logic            go_alu;
	sme_pkg::alu_op_t alu_op;

	logic            stk_we;
	logic [SAW-1:0]  stk_waddr;
	logic [63:0]     stk_wdata;
	logic            ram_we;
	logic [RAW-1:0]  ram_waddr;
	logic [63:0]     ram_wdata;

	sme_pkg::alu_req_t alu_req;
	sme_pkg::alu_rsp_t alu_rsp;

	sme_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	assign accept    = cmd.valid && cmd.ready;
	assign slot_free = !ovalid_q || rsp.ready;
	assign cmd.ready = (state_q == sme_pkg::S_IDLE);

	// operand location, resolved at accept
	always_comb begin
		ridx     = RIW'(cmd.reg_index);
		reg_ok   = (5'(cmd.reg_index) < 5'(NUM_REGS));
		rval     = regs_q[ridx];
		addr_src = (cmd.arg_kind == sme_pkg::KIND_RAM_REG) ? rval : cmd.immediate;
		ram_ok   = !addr_src[63] && (addr_src[63:32] < 32'(RAM_WORDS));
		case (cmd.arg_kind)
			sme_pkg::KIND_IMM:     opst = sme_pkg::ST_OK;
			sme_pkg::KIND_REG:     opst = reg_ok ? sme_pkg::ST_OK : sme_pkg::ST_BADARG;
			sme_pkg::KIND_RAM_IMM: opst = ram_ok ? sme_pkg::ST_OK : sme_pkg::ST_RAM;
			default: begin
				if (!reg_ok) begin
					opst = sme_pkg::ST_BADARG;
				end else begin
					opst = ram_ok ? sme_pkg::ST_OK : sme_pkg::ST_RAM;
				end
			end
		endcase
		sc_m1 = sc_q - SCW'(1);
		sc_m2 = sc_q - SCW'(2);
	end

	// execute decision
	always_comb begin
		case (kind_q)
			sme_pkg::KIND_IMM: v_opnd = imm_q;
			sme_pkg::KIND_REG: v_opnd = rval_q;
			default:           v_opnd = ramrd_q;
		endcase
		next_len = pc_q + (kind_q[0] ? 16'd2 : 16'd9);
		target   = v_opnd[47:32];
		case (mode_q)
			sme_pkg::OP_JE:  take = (top_q == sec_q);
			sme_pkg::OP_JA:  take = ($signed(sec_q) < $signed(top_q));
			sme_pkg::OP_JB:  take = ($signed(top_q) < $signed(sec_q));
			sme_pkg::OP_JAE: take = !($signed(top_q) < $signed(sec_q));
			sme_pkg::OP_JBE: take = !($signed(sec_q) < $signed(top_q));
			default:         take = (top_q != sec_q);
		endcase

		ex_st   = sme_pkg::ST_OK;
		ex_next = pc_q + 16'd1;
		ex_ov   = '0;
		ex_ovld = 1'b0;
		stk_wr  = 1'b0;
		stk_wa  = sc_q[SAW-1:0];
		stk_wd  = v_opnd;
		sc_nxt  = sc_q;
		reg_wr  = 1'b0;
		ram_wr  = 1'b0;
		go_alu  = 1'b0;
		alu_op  = sme_pkg::ALU_MUL;

		case (mode_q)
			sme_pkg::OP_PUSH: begin
				if (opst_q != sme_pkg::ST_OK) begin
					ex_st = opst_q;
				end else if (sc_q >= SCW'(STACK_DEPTH)) begin
					ex_st = sme_pkg::ST_STACK;
				end else begin
					stk_wr  = 1'b1;
					sc_nxt  = sc_q + SCW'(1);
					ex_next = next_len;
				end
			end
			sme_pkg::OP_POP: begin
				if (sc_q == '0) begin
					ex_st = sme_pkg::ST_STACK;
				end else if (kind_q == sme_pkg::KIND_IMM) begin
					ex_st = sme_pkg::ST_BADARG;
				end else if (opst_q != sme_pkg::ST_OK) begin
					ex_st = opst_q;
				end else begin
					reg_wr  = (kind_q == sme_pkg::KIND_REG);
					ram_wr  = (kind_q != sme_pkg::KIND_REG);
					sc_nxt  = sc_m1;
					ex_next = next_len;
				end
			end
			sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
				if (sc_q < SCW'(2)) begin
					ex_st = sme_pkg::ST_STACK;
				end else if ((mode_q == sme_pkg::OP_DIV) && (top_q == '0)) begin
					ex_st = sme_pkg::ST_ARITH;
				end else begin
					stk_wa = sc_m2[SAW-1:0];
					sc_nxt = sc_m1;
					stk_wd = (mode_q == sme_pkg::OP_ADD) ? sme_pkg::q_add(top_q, sec_q)
						: sme_pkg::q_sub(sec_q, top_q);
					if (mode_q inside {sme_pkg::OP_ADD, sme_pkg::OP_SUB}) begin
						stk_wr = 1'b1;
					end else begin
						go_alu = 1'b1;
						alu_op = (mode_q == sme_pkg::OP_MUL) ? sme_pkg::ALU_MUL
							: sme_pkg::ALU_DIV;
					end
				end
			end
			sme_pkg::OP_SQRT: begin
				if (sc_q == '0) begin
					ex_st = sme_pkg::ST_STACK;
				end else if (top_q[63]) begin
					ex_st = sme_pkg::ST_ARITH;
				end else begin
					stk_wa = sc_m1[SAW-1:0];
					go_alu = 1'b1;
					alu_op = sme_pkg::ALU_SQRT;
				end
			end
			sme_pkg::OP_OUT: begin
				if (sc_q == '0) begin
					ex_st = sme_pkg::ST_STACK;
				end else begin
					ex_ov   = top_q;
					ex_ovld = 1'b1;
					sc_nxt  = sc_m1;
				end
			end
			sme_pkg::OP_IN: begin
				if (sc_q >= SCW'(STACK_DEPTH)) begin
					ex_st = sme_pkg::ST_STACK;
				end else begin
					stk_wr = 1'b1;
					stk_wd = inv_q;
					sc_nxt = sc_q + SCW'(1);
				end
			end
			sme_pkg::OP_JMP: begin
				if (opst_q != sme_pkg::ST_OK) begin
					ex_st = opst_q;
				end else begin
					ex_next = target;
				end
			end
			sme_pkg::OP_JE, sme_pkg::OP_JA, sme_pkg::OP_JB, sme_pkg::OP_JAE,
			sme_pkg::OP_JBE, sme_pkg::OP_JNE: begin
				if (sc_q < SCW'(2)) begin
					ex_st = sme_pkg::ST_STACK;
				end else if (!take) begin
					ex_next = pc_q + 16'd9;
					sc_nxt  = sc_m2;
				end else if (opst_q != sme_pkg::ST_OK) begin
					ex_st = opst_q;
				end else begin
					ex_next = target;
					sc_nxt  = sc_m2;
				end
			end
			sme_pkg::OP_CALL: begin
				if (sc_q >= SCW'(STACK_DEPTH)) begin
					ex_st = sme_pkg::ST_STACK;
				end else if (opst_q != sme_pkg::ST_OK) begin
					ex_st = opst_q;
				end else begin
					stk_wr  = 1'b1;
					stk_wd  = {15'd0, 17'(pc_q) + 17'd9, 32'd0};
					sc_nxt  = sc_q + SCW'(1);
					ex_next = target;
				end
			end
			sme_pkg::OP_RET: begin
				if (sc_q == '0) begin
					ex_st = sme_pkg::ST_STACK;
				end else begin
					ex_next = top_q[47:32];
					sc_nxt  = sc_m1;
				end
			end
			sme_pkg::OP_HLT: ex_st = sme_pkg::ST_HALT;
			default:         ex_st = sme_pkg::ST_BADOP;
		endcase

		if (ex_st != sme_pkg::ST_OK) begin
			ex_next = pc_q;
			ex_ov   = '0;
			ex_ovld = 1'b0;
		end
	end

	always_comb begin
		alu_req.start = (state_q == sme_pkg::S_EXEC) && go_alu;
		alu_req.op    = alu_op;
		alu_req.top   = top_q;
		alu_req.sec   = sec_q;

		if (state_q == sme_pkg::S_ALU) begin
			stk_we    = alu_rsp.done;
			stk_waddr = wb_addr_q;
			stk_wdata = alu_rsp.result;
		end else begin
			stk_we    = (state_q == sme_pkg::S_EXEC) && stk_wr;
			stk_waddr = stk_wa;
			stk_wdata = stk_wd;
		end

		if (state_q == sme_pkg::S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == sme_pkg::S_EXEC) && ram_wr;
			ram_waddr = raddr_q;
			ram_wdata = top_q;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		top_q <= stk_mem[sc_m1[SAW-1:0]];
		sec_q <= stk_mem[sc_m2[SAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			ram_mem[ram_waddr] <= ram_wdata;
		end
		ramrd_q <= ram_mem[addr_src[32 +: RAW]];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sme_pkg::S_CLEAR;
			sc_q     <= '0;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			if ((state_q == sme_pkg::S_EXEC) && reg_wr) begin
				regs_q[ridx_q] <= top_q;
			end
			if ((state_q == sme_pkg::S_RESP) && slot_free) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				sme_pkg::S_CLEAR: begin
					clr_q <= clr_q + RAW'(1);
					if (clr_q == RAW'(RAM_WORDS - 1)) begin
						state_q <= sme_pkg::S_IDLE;
					end
				end
				sme_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= sme_pkg::S_EXEC;
					end
				end
				sme_pkg::S_EXEC: begin
					if (go_alu) begin
						state_q <= sme_pkg::S_ALU;
					end else begin
						state_q <= sme_pkg::S_RESP;
						if (ex_st == sme_pkg::ST_OK) begin
							sc_q <= sc_nxt;
						end
					end
				end
				sme_pkg::S_ALU: begin
					if (alu_rsp.done) begin
						state_q <= sme_pkg::S_RESP;
						sc_q    <= wb_sc_q;
					end
				end
				sme_pkg::S_RESP: begin
					if (slot_free) begin
						state_q <= sme_pkg::S_IDLE;
					end
				end
				default: state_q <= sme_pkg::S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= cmd.mode;
			kind_q  <= cmd.arg_kind;
			ridx_q  <= ridx;
			imm_q   <= cmd.immediate;
			pc_q    <= cmd.pc;
			inv_q   <= cmd.in_value;
			rval_q  <= rval;
			opst_q  <= opst;
			raddr_q <= addr_src[32 +: RAW];
		end
		if (state_q == sme_pkg::S_EXEC) begin
			wb_addr_q  <= stk_wa;
			wb_sc_q    <= sc_nxt;
			res_next_q <= ex_next;
			res_ov_q   <= ex_ov;
			res_ovld_q <= ex_ovld;
			res_st_q   <= ex_st;
		end
		if ((state_q == sme_pkg::S_RESP) && slot_free) begin
			onext_q <= res_next_q;
			oval_q  <= res_ov_q;
			oflag_q <= res_ovld_q;
			ost_q   <= res_st_q;
		end
	end

	assign rsp.valid     = ovalid_q;
	assign rsp.next_pc   = onext_q;
	assign rsp.out_value = oval_q;
	assign rsp.out_valid = oflag_q;
	assign rsp.status    = ost_q;

endmodule

`default_nettype wire

### design/sme_chk.sv
// ----------------------------------------------------------------------------
// sme_chk: port-level checks of the stack machine executor
// One item in flight, result consistency, stall behavior of rsp.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [15:0] rsp_next_pc,
	input wire logic [63:0] rsp_out_value,
	input wire logic        rsp_out_valid,
	input wire logic [2:0]  rsp_status
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("cmd accepted while an item is in flight");

	a_out_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_out_valid |-> rsp_status == sme_pkg::ST_OK)
		else $error("out flag set on a failed item");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != sme_pkg::ST_OK) |-> (rsp_out_value == '0) && !rsp_out_valid)
		else $error("failed item carries an out value");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc)
			&& $stable(rsp_out_value) && $stable(rsp_out_valid) && $stable(rsp_status))
		else $error("rsp item changed while stalled");

endmodule

bind stack_machine_executor sme_chk u_sme_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_next_pc   (rsp.next_pc),
	.rsp_out_value (rsp.out_value),
	.rsp_out_valid (rsp.out_valid),
	.rsp_status    (rsp.status)
);

`default_nettype wire

### tb/tb_stack_machine_executor.sv
// ----------------------------------------------------------------------------
// tb_stack_machine_executor: self-checking bench for the stack machine executor
// Drives decoded instructions through the cmd channel with random gaps and
// checks every rsp item against an in-bench model of the stack, registers and
// RAM, including saturation, jump targets and all error codes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stack_machine_executor;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int NREGS = 4;
	localparam int NRAM = 256;
	localparam int N_RANDOM = 1250;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [4:0]  mode;
		logic [1:0]  kind;
		logic [1:0]  reg_idx;
		logic [63:0] imm;
		logic [15:0] pc;
		logic [63:0] inv;
		logic [4:0]  gap;
		logic        drain;
	} instr_t;

	typedef struct packed {
		logic [15:0]       next_pc;
		logic [63:0]       out_value;
		logic              out_valid;
		sme_pkg::status_t  status;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sme_cmd_if cmd_ch();
	sme_rsp_if rsp_ch();

	stack_machine_executor uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	// copy 0 tracks the generator, copy 1 tracks accepted items
	logic [63:0] stk[2][DEPTH];
	int unsigned depth[2];
	logic [63:0] regs[2][NREGS];
	logic [63:0] ram[2][NRAM];

	instr_t pending_q[$];
	result_t expected_q[$];
	int errors = 0;
	int cycles = 0;
	int gap_mode = 0;

	function automatic logic [63:0] abs_q(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] sat_q(input logic neg, input logic [63:0] m,
			input logic ovf);
		if (neg) begin
			return (ovf || m > sme_pkg::Q_MIN) ? sme_pkg::Q_MIN : (64'd0 - m);
		end
		return (ovf || m > sme_pkg::Q_MAX) ? sme_pkg::Q_MAX : m;
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			return a[63] ? sme_pkg::Q_MIN : sme_pkg::Q_MAX;
		end
		return s;
	endfunction

	function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] d;
		d = a - b;
		if (a[63] != b[63] && d[63] != a[63]) begin
			return a[63] ? sme_pkg::Q_MIN : sme_pkg::Q_MAX;
		end
		return d;
	endfunction

	function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, abs_q(a)} * {64'd0, abs_q(b)};
		return sat_q(a[63] ^ b[63], p[95:32], |p[127:96]);
	endfunction

	function automatic logic [63:0] div_q(input logic [63:0] num, input logic [63:0] den);
		logic [95:0] q;
		q = {abs_q(num), 32'd0} / {32'd0, abs_q(den)};
		return sat_q(num[63] ^ den[63], q[63:0], |q[95:64]);
	endfunction

	function automatic logic [63:0] root_q(input logic [63:0] x);
		logic [127:0] goal;
		logic [127:0] sq;
		logic [63:0] r;
		logic [63:0] c;
		goal = {32'd0, x, 32'd0};
		r = 64'd0;
		for (int b = 47; b >= 0; b--) begin
			c = r | (64'd1 << b);
			sq = {64'd0, c} * {64'd0, c};
			if (sq <= goal) begin
				r = c;
			end
		end
		return r;
	endfunction

	function automatic sme_pkg::status_t find_slot(input int w, input instr_t it,
			output logic in_ram, output int idx, output int len);
		logic [63:0] a;
		in_ram = 1'b1;
		idx = 0;
		if (it.kind == sme_pkg::KIND_REG || it.kind == sme_pkg::KIND_RAM_REG) begin
			len = 1;
			if (int'(it.reg_idx) >= NREGS) begin
				return sme_pkg::ST_BADARG;
			end
			if (it.kind == sme_pkg::KIND_REG) begin
				in_ram = 1'b0;
				idx = int'(it.reg_idx);
				return sme_pkg::ST_OK;
			end
			a = regs[w][it.reg_idx];
		end else begin
			len = 8;
			a = it.imm;
		end
		if (a[63] || a[62:32] >= NRAM) begin
			return sme_pkg::ST_RAM;
		end
		idx = int'(a[62:32]);
		return sme_pkg::ST_OK;
	endfunction

	function automatic sme_pkg::status_t read_arg(input int w, input instr_t it,
			output logic [63:0] v, output int len);
		logic in_ram;
		int idx;
		sme_pkg::status_t st;
		v = 64'd0;
		if (it.kind == sme_pkg::KIND_IMM) begin
			v = it.imm;
			len = 8;
			return sme_pkg::ST_OK;
		end
		st = find_slot(w, it, in_ram, idx, len);
		if (st == sme_pkg::ST_OK) begin
			v = in_ram ? ram[w][idx] : regs[w][idx];
		end
		return st;
	endfunction

	function automatic result_t execute(input int w, input instr_t it);
		result_t r;
		sme_pkg::status_t st;
		logic [63:0] v;
		logic [63:0] top;
		logic [63:0] sec;
		logic [63:0] res;
		logic in_ram;
		logic take;
		int len;
		int idx;
		int unsigned n;
		int unsigned nxt;
		n = depth[w];
		st = sme_pkg::ST_OK;
		nxt = it.pc;
		r.out_value = 64'd0;
		r.out_valid = 1'b0;
		top = (n >= 1) ? stk[w][n - 1] : 64'd0;
		sec = (n >= 2) ? stk[w][n - 2] : 64'd0;
		case (it.mode)
			sme_pkg::OP_PUSH: begin
				st = read_arg(w, it, v, len);
				if (st == sme_pkg::ST_OK) begin
					if (n >= DEPTH) begin
						st = sme_pkg::ST_STACK;
					end else begin
						stk[w][n] = v;
						depth[w] = n + 1;
						nxt = it.pc + 1 + len;
					end
				end
			end
			sme_pkg::OP_POP: begin
				if (n == 0) begin
					st = sme_pkg::ST_STACK;
				end else if (it.kind == sme_pkg::KIND_IMM) begin
					st = sme_pkg::ST_BADARG;
				end else begin
					st = find_slot(w, it, in_ram, idx, len);
					if (st == sme_pkg::ST_OK) begin
						if (in_ram) begin
							ram[w][idx] = top;
						end else begin
							regs[w][idx] = top;
						end
						depth[w] = n - 1;
						nxt = it.pc + 1 + len;
					end
				end
			end
			sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
				if (n < 2) begin
					st = sme_pkg::ST_STACK;
				end else if (it.mode == sme_pkg::OP_DIV && top == 64'd0) begin
					st = sme_pkg::ST_ARITH;
				end else begin
					case (it.mode)
						sme_pkg::OP_ADD: res = add_sat(top, sec);
						sme_pkg::OP_SUB: res = sub_sat(sec, top);
						sme_pkg::OP_MUL: res = mul_q(top, sec);
						default: res = div_q(sec, top);
					endcase
					stk[w][n - 2] = res;
					depth[w] = n - 1;
					nxt = it.pc + 1;
				end
			end
			sme_pkg::OP_SQRT: begin
				if (n == 0) begin
					st = sme_pkg::ST_STACK;
				end else if (top[63]) begin
					st = sme_pkg::ST_ARITH;
				end else begin
					stk[w][n - 1] = root_q(top);
					nxt = it.pc + 1;
				end
			end
			sme_pkg::OP_OUT: begin
				if (n == 0) begin
					st = sme_pkg::ST_STACK;
				end else begin
					r.out_value = top;
					r.out_valid = 1'b1;
					depth[w] = n - 1;
					nxt = it.pc + 1;
				end
			end
			sme_pkg::OP_IN: begin
				if (n >= DEPTH) begin
					st = sme_pkg::ST_STACK;
				end else begin
					stk[w][n] = it.inv;
					depth[w] = n + 1;
					nxt = it.pc + 1;
				end
			end
			sme_pkg::OP_JMP: begin
				st = read_arg(w, it, v, len);
				if (st == sme_pkg::ST_OK) begin
					nxt = v[47:32];
				end
			end
			sme_pkg::OP_JE, sme_pkg::OP_JA, sme_pkg::OP_JB, sme_pkg::OP_JAE,
			sme_pkg::OP_JBE, sme_pkg::OP_JNE: begin
				if (n < 2) begin
					st = sme_pkg::ST_STACK;
				end else begin
					case (it.mode)
						sme_pkg::OP_JE: take = (top == sec);
						sme_pkg::OP_JA: take = ($signed(top) > $signed(sec));
						sme_pkg::OP_JB: take = ($signed(top) < $signed(sec));
						sme_pkg::OP_JAE: take = ($signed(top) >= $signed(sec));
						sme_pkg::OP_JBE: take = ($signed(top) <= $signed(sec));
						default: take = (top != sec);
					endcase
					if (take) begin
						st = read_arg(w, it, v, len);
						nxt = v[47:32];
					end else begin
						nxt = it.pc + 9;
					end
					if (st == sme_pkg::ST_OK) begin
						depth[w] = n - 2;
					end
				end
			end
			sme_pkg::OP_CALL: begin
				if (n >= DEPTH) begin
					st = sme_pkg::ST_STACK;
				end else begin
					st = read_arg(w, it, v, len);
					if (st == sme_pkg::ST_OK) begin
						stk[w][n] = (64'(it.pc) + 64'd9) << 32;
						depth[w] = n + 1;
						nxt = v[47:32];
					end
				end
			end
			sme_pkg::OP_RET: begin
				if (n == 0) begin
					st = sme_pkg::ST_STACK;
				end else begin
					depth[w] = n - 1;
					nxt = top[47:32];
				end
			end
			sme_pkg::OP_HLT: st = sme_pkg::ST_HALT;
			default: st = sme_pkg::ST_BADOP;
		endcase
		if (st != sme_pkg::ST_OK) begin
			nxt = it.pc;
			r.out_value = 64'd0;
			r.out_valid = 1'b0;
		end
		r.next_pc = nxt[15:0];
		r.status = st;
		return r;
	endfunction

	function automatic logic [63:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			return {1'b0, 31'($urandom_range(0, 300)), 32'($urandom)};
		end else if (sel < 65) begin
			return {32'($urandom), 32'($urandom)};
		end else if (sel < 85) begin
			return {32'($signed($urandom_range(0, 20)) - 10), 32'($urandom)};
		end
		case ($urandom_range(0, 4))
			0: return sme_pkg::Q_MIN;
			1: return sme_pkg::Q_MAX;
			2: return 64'd0;
			3: return 64'h1_0000_0000;
			default: return 64'hFFFF_FFFF_0000_0000;
		endcase
	endfunction

	task automatic queue_instr(input logic [4:0] mode, input logic [1:0] kind,
			input logic [1:0] reg_idx, input logic [63:0] imm, input logic drain);
		instr_t it;
		result_t unused;
		it.mode = mode;
		it.kind = kind;
		it.reg_idx = reg_idx;
		it.imm = imm;
		it.pc = 16'($urandom);
		it.inv = pick_value();
		it.drain = drain;
		if (gap_mode == 0 || $urandom_range(0, 1) == 0) begin
			it.gap = 5'd0;
		end else begin
			it.gap = 5'($urandom_range(0, 18));
		end
		unused = execute(0, it);
		pending_q.push_back(it);
	endtask

	task automatic queue_random(input logic drain);
		logic [4:0] mode;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 5) begin
			mode = 5'($urandom_range(0, 31));
		end else if (depth[0] < 2 && sel < 80) begin
			mode = ($urandom_range(0, 2) == 0) ? sme_pkg::OP_IN : sme_pkg::OP_PUSH;
		end else if (depth[0] > 60 && sel < 70) begin
			mode = 5'($urandom_range(sme_pkg::OP_POP, sme_pkg::OP_OUT));
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 25) mode = sme_pkg::OP_PUSH;
			else if (sel < 35) mode = sme_pkg::OP_POP;
			else if (sel < 55) mode = 5'($urandom_range(sme_pkg::OP_ADD, sme_pkg::OP_SQRT));
			else if (sel < 63) mode = sme_pkg::OP_OUT;
			else if (sel < 71) mode = sme_pkg::OP_IN;
			else if (sel < 75) mode = sme_pkg::OP_JMP;
			else if (sel < 87) mode = 5'($urandom_range(sme_pkg::OP_JE, sme_pkg::OP_JNE));
			else if (sel < 93) mode = sme_pkg::OP_CALL;
			else if (sel < 98) mode = sme_pkg::OP_RET;
			else mode = sme_pkg::OP_HLT;
		end
		queue_instr(mode, 2'($urandom), 2'($urandom), pick_value(), drain);
	endtask

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = '0;
		cmd_ch.arg_kind = '0;
		cmd_ch.reg_index = '0;
		cmd_ch.immediate = '0;
		cmd_ch.pc = '0;
		cmd_ch.in_value = '0;
		rsp_ch.ready = 1'b0;
		for (int w = 0; w < 2; w++) begin
			depth[w] = 0;
			for (int i = 0; i < DEPTH; i++) stk[w][i] = 64'd0;
			for (int i = 0; i < NREGS; i++) regs[w][i] = 64'd0;
			for (int i = 0; i < NRAM; i++) ram[w][i] = 64'd0;
		end

		queue_instr(sme_pkg::OP_POP, sme_pkg::KIND_REG, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_OUT, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_ADD, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_PUSH, sme_pkg::KIND_IMM, 2'd0, sme_pkg::Q_MAX, 1'b0);
		queue_instr(sme_pkg::OP_PUSH, sme_pkg::KIND_IMM, 2'd0, 64'h1_0000_0000, 1'b0);
		queue_instr(sme_pkg::OP_ADD, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_PUSH, sme_pkg::KIND_IMM, 2'd0, sme_pkg::Q_MIN, 1'b0);
		queue_instr(sme_pkg::OP_SUB, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_PUSH, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_DIV, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_POP, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_POP, sme_pkg::KIND_RAM_IMM, 2'd0, 64'd300 << 32, 1'b0);
		queue_instr(sme_pkg::OP_POP, sme_pkg::KIND_RAM_IMM, 2'd0, 64'd5 << 32, 1'b0);
		queue_instr(sme_pkg::OP_PUSH, sme_pkg::KIND_IMM, 2'd0, sme_pkg::Q_MAX, 1'b0);
		queue_instr(sme_pkg::OP_MUL, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_PUSH, sme_pkg::KIND_IMM, 2'd0, 64'hFFFF_FFFC_0000_0000,
			1'b0);
		queue_instr(sme_pkg::OP_SQRT, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_OUT, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_PUSH, sme_pkg::KIND_IMM, 2'd0, 64'd16 << 32, 1'b0);
		queue_instr(sme_pkg::OP_SQRT, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_IN, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_JE, sme_pkg::KIND_IMM, 2'd0, 64'h1234_5678_0000_0000,
			1'b0);
		queue_instr(sme_pkg::OP_PUSH, sme_pkg::KIND_IMM, 2'd0, 64'd3 << 32, 1'b0);
		queue_instr(sme_pkg::OP_POP, sme_pkg::KIND_REG, 2'd2, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_PUSH, sme_pkg::KIND_RAM_REG, 2'd2, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_CALL, sme_pkg::KIND_REG, 2'd2, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_RET, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_HLT, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(5'd31, sme_pkg::KIND_IMM, 2'd0, 64'd0, 1'b0);
		queue_instr(sme_pkg::OP_JMP, sme_pkg::KIND_RAM_IMM, 2'd0, sme_pkg::Q_MIN, 1'b0);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 100 == 0) begin
				gap_mode = $urandom_range(0, 2);
			end
			if (i % 400 == 200) begin
				for (int k = 0; k < DEPTH + 3; k++) begin
					queue_instr(sme_pkg::OP_PUSH, 2'($urandom), 2'($urandom), pick_value(),
						1'b0);
				end
			end
			queue_random(i % 500 == 250);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || cmd_ch.valid || expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (120) @(posedge clk);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	int wait_cnt = 0;
	logic armed = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		instr_t it;
		logic nv;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			wait_cnt = 0;
			armed = 1'b0;
		end else begin
			nv = cmd_ch.valid;
			if (cmd_ch.valid && cmd_ch.ready) begin
				it.mode = cmd_ch.mode;
				it.kind = cmd_ch.arg_kind;
				it.reg_idx = cmd_ch.reg_index;
				it.imm = cmd_ch.immediate;
				it.pc = cmd_ch.pc;
				it.inv = cmd_ch.in_value;
				it.gap = '0;
				it.drain = 1'b0;
				expected_q.push_back(execute(1, it));
				nv = 1'b0;
			end
			if (!nv && pending_q.size() != 0) begin
				if (!armed) begin
					wait_cnt = pending_q[0].gap;
					armed = 1'b1;
				end
				if (wait_cnt > 0) begin
					wait_cnt--;
				end else if (!pending_q[0].drain || expected_q.size() == 0) begin
					it = pending_q.pop_front();
					armed = 1'b0;
					nv = 1'b1;
					cmd_ch.mode <= it.mode;
					cmd_ch.arg_kind <= it.kind;
					cmd_ch.reg_index <= it.reg_idx;
					cmd_ch.immediate <= it.imm;
					cmd_ch.pc <= it.pc;
					cmd_ch.in_value <= it.inv;
				end
			end
			cmd_ch.valid <= nv;
		end
	end

	int stall_cnt = 0;
	int stall_mode = 0;
	int seen = 0;

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_cnt = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen++;
				if (seen % 80 == 0) begin
					stall_mode = $urandom_range(0, 2);
				end
				if (expected_q.size() == 0) begin
					$error("unexpected result: next_pc %h status %0d", rsp_ch.next_pc,
						rsp_ch.status);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (rsp_ch.next_pc !== want.next_pc) begin
						$error("next_pc: expected %h, got %h", want.next_pc, rsp_ch.next_pc);
						errors++;
					end
					if (rsp_ch.out_value !== want.out_value) begin
						$error("out_value: expected %h, got %h", want.out_value,
							rsp_ch.out_value);
						errors++;
					end
					if (rsp_ch.out_valid !== want.out_valid) begin
						$error("out_valid: expected %b, got %b", want.out_valid,
							rsp_ch.out_valid);
						errors++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						errors++;
					end
				end
				stall_cnt = (stall_mode == 0 || $urandom_range(0, 1) == 0) ? 0 :
					$urandom_range(0, 18);
			end else if (stall_cnt > 0) begin
				stall_cnt--;
			end
			rsp_ch.ready <= (stall_cnt == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule

`default_nettype wire
